FILE: rtl/bgi_pkg.sv
package bgi_pkg;

	// Default grid shape and table count.
	localparam int GRID_X_DEFAULT      = 80;
	localparam int GRID_Y_DEFAULT      = 80;
	localparam int TABLE_COUNT_DEFAULT = 4;

	// Fixed field widths.
	localparam int TSEL_W    = 2;
	localparam int TEMP_W    = 18;
	localparam int PRES_W    = 20;
	localparam int WORD_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int FRAC_W    = FRAC_BITS + 1;
	localparam int PADDR_W   = 5;

	// Depth of the queue between the front and back ends.
	localparam int QUEUE_DEPTH = 4;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_X_LOW       = 3'd0;
	localparam logic [2:0] REG_X_HIGH      = 3'd1;
	localparam logic [2:0] REG_Y_LOW       = 3'd2;
	localparam logic [2:0] REG_Y_HIGH      = 3'd3;
	localparam logic [2:0] REG_X_SCALE     = 3'd4;
	localparam logic [2:0] REG_Y_SCALE     = 3'd5;
	localparam logic [2:0] REG_LINE_SLOPE  = 3'd6;
	localparam logic [2:0] REG_LINE_OFFSET = 3'd7;

	// Register reset values.
	localparam logic [17:0] X_LOW_RESET       = 18'd64000;
	localparam logic [17:0] X_HIGH_RESET      = 18'd128000;
	localparam logic [19:0] Y_LOW_RESET       = 20'd131072;
	localparam logic [19:0] Y_HIGH_RESET      = 20'd458752;
	localparam logic [23:0] X_SCALE_RESET     = 24'd5301600;
	localparam logic [23:0] Y_SCALE_RESET     = 24'd1035469;
	localparam logic [15:0] LINE_SLOPE_RESET  = 16'd4800;
	localparam logic [17:0] LINE_OFFSET_RESET = 18'd106880;

	// Configuration register set.
	typedef struct packed {
		logic [17:0] x_low;
		logic [17:0] x_high;
		logic [19:0] y_low;
		logic [19:0] y_high;
		logic [23:0] x_scale;
		logic [23:0] y_scale;
		logic [15:0] line_slope;
		logic [17:0] line_offset;
	} cfg_t;

	// What the back end does with a word.
	typedef enum logic [1:0] {
		KIND_LOOKUP,
		KIND_STORE,
		KIND_NULL
	} kind_t;

	// Control part of a word passed from front to back.
	typedef struct packed {
		kind_t kind;
		logic  flag;
	} ctl_t;

endpackage

FILE: rtl/bgi_ifs.sv
// Input item channel.
interface bgi_item_if #(
	parameter int IdxW = 13
);
	logic                             valid;
	logic                             ready;
	logic                             operation;
	logic [bgi_pkg::TSEL_W-1:0]       table_select;
	logic [bgi_pkg::TEMP_W-1:0]       temperature;
	logic [bgi_pkg::PRES_W-1:0]       pressure;
	logic [IdxW-1:0]                  entry_index;
	logic signed [bgi_pkg::WORD_W-1:0] entry_value;

	modport source (
		output valid, operation, table_select, temperature, pressure,
		entry_index, entry_value,
		input ready
	);
	modport sink (
		input valid, operation, table_select, temperature, pressure,
		entry_index, entry_value,
		output ready
	);
endinterface

// Result channel.
interface bgi_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [bgi_pkg::WORD_W-1:0] value;
	logic                              out_of_range;

	modport source (output valid, value, out_of_range, input ready);
	modport sink (input valid, value, out_of_range, output ready);
endinterface

FILE: rtl/bgi_front.sv
module bgi_front #(
	parameter int GRID_X = 80,
	parameter int GRID_Y = 80,
	parameter int TABLE_COUNT = 4,
	localparam int IdxW = $clog2(GRID_X * GRID_Y),
	localparam int RowW = $clog2(GRID_X),
	localparam int ColW = $clog2(GRID_Y)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bgi_pkg::cfg_t                  cfg,
	bgi_item_if.sink                       item,
	output logic                           work_valid,
	input  logic                           work_full,
	output bgi_pkg::ctl_t                  work_ctl,
	output logic [bgi_pkg::TSEL_W-1:0]     work_tsel,
	output logic [RowW-1:0]                work_row,
	output logic [ColW-1:0]                work_col,
	output logic [bgi_pkg::FRAC_W-1:0]     work_ft,
	output logic [bgi_pkg::FRAC_W-1:0]     work_fs,
	output logic [bgi_pkg::WORD_W-1:0]     work_data
);
	import bgi_pkg::*;

	// Exact division of the entry index by GRID_Y through a reciprocal.
	localparam int DivW     = $clog2(GRID_Y);
	localparam int DivShift = IdxW + DivW;
	localparam int RecipW   = DivShift + 1;
	localparam longint Recip = ((longint'(1) << DivShift) + GRID_Y - 1) / GRID_Y;
	localparam int RprodW   = RecipW + IdxW;

	// Grid position limits.
	localparam int PosXW = RowW + FRAC_BITS;
	localparam int PosYW = ColW + FRAC_BITS;
	localparam longint CellsX = longint'(GRID_X - 1) << FRAC_BITS;
	localparam longint CellsY = longint'(GRID_Y - 1) << FRAC_BITS;

	logic adv;

	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic                op_s1;
	logic [TSEL_W-1:0]   tsel_s1, tsel_s2, tsel_s3;
	logic [TEMP_W-1:0]   temp_s1, temp_s2;
	logic [PRES_W-1:0]   pres_s1;
	logic [IdxW-1:0]     eidx_s1, eidx_s2, eidx_s3;
	logic [WORD_W-1:0]   eval_s1, eval_s2, eval_s3;

	kind_t               kind_c, kind_s2, kind_s3;
	logic                flag_c, flag_s2, flag_s3;
	logic [TEMP_W-1:0]   dx_c, dx_s2;
	logic [PRES_W-1:0]   dy_c, dy_s2;
	logic [35:0]         slope_prod_c, slope_prod_s2;
	logic [RprodW-1:0]   row_prod_c, row_prod_s2;
	logic                tbl_ok_c, idx_ok_c, range_c;

	logic [41:0]         prodx_c;
	logic [43:0]         prody_c;
	logic [36:0]         lhs_c, rhs_c;
	logic [25:0]         posx_raw_s3;
	logic [27:0]         posy_raw_s3;
	logic [RowW-1:0]     row_s3;

	logic [PosXW-1:0]    posx_c;
	logic [PosYW-1:0]    posy_c;
	logic [RowW-1:0]     ix_c, i_c;
	logic [ColW-1:0]     jy_c, j_c, col_c;

	// The front end moves whenever its last stage can hand over.
	assign adv        = !valid_s4 || !work_full;
	assign item.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Input register.
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= item.operation;
			tsel_s1 <= item.table_select;
			temp_s1 <= item.temperature;
			pres_s1 <= item.pressure;
			eidx_s1 <= IdxW'(item.entry_index);
			eval_s1 <= item.entry_value;
		end
	end

	// Classify the word, check ranges, offset the inputs from the grid origin.
	assign tbl_ok_c = 32'(tsel_s1) < 32'(TABLE_COUNT);
	assign idx_ok_c = 32'(eidx_s1) < 32'(GRID_X * GRID_Y);
	assign range_c  = (temp_s1 < cfg.x_low) || (temp_s1 > cfg.x_high) ||
		(pres_s1 < cfg.y_low) || (pres_s1 > cfg.y_high);
	assign dx_c = (temp_s1 > cfg.x_low) ? temp_s1 - cfg.x_low : '0;
	assign dy_c = (pres_s1 > cfg.y_low) ? pres_s1 - cfg.y_low : '0;
	assign slope_prod_c = 36'(cfg.line_slope) * 36'(pres_s1);
	assign row_prod_c   = RprodW'(eidx_s1) * RprodW'(Recip);

	always_comb begin
		if (op_s1) begin
			kind_c = (tbl_ok_c && idx_ok_c) ? KIND_STORE : KIND_NULL;
			flag_c = 1'b0;
		end else begin
			kind_c = tbl_ok_c ? KIND_LOOKUP : KIND_NULL;
			flag_c = !tbl_ok_c || range_c;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s2       <= kind_c;
			flag_s2       <= flag_c;
			tsel_s2       <= tsel_s1;
			temp_s2       <= temp_s1;
			dx_s2         <= dx_c;
			dy_s2         <= dy_c;
			slope_prod_s2 <= slope_prod_c;
			row_prod_s2   <= row_prod_c;
			eidx_s2       <= eidx_s1;
			eval_s2       <= eval_s1;
		end
	end

	// Scale to grid positions and compare against the limit line.
	assign prodx_c = 42'(dx_s2) * 42'(cfg.x_scale);
	assign prody_c = 44'(dy_s2) * 44'(cfg.y_scale);
	assign lhs_c   = 37'({temp_s2, 16'h0000});
	assign rhs_c   = 37'({cfg.line_offset, 16'h0000}) + 37'(slope_prod_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s3     <= kind_s2;
			flag_s3     <= flag_s2 || (kind_s2 == KIND_LOOKUP && lhs_c >= rhs_c);
			tsel_s3     <= tsel_s2;
			posx_raw_s3 <= prodx_c[41:16];
			posy_raw_s3 <= prody_c[43:16];
			row_s3      <= row_prod_s2[DivShift +: RowW];
			eidx_s3     <= eidx_s2;
			eval_s3     <= eval_s2;
		end
	end

	// Saturate positions, clamp to the last full cell, split off fractions.
	assign posx_c = (posx_raw_s3 > 26'(CellsX)) ? PosXW'(CellsX) : posx_raw_s3[PosXW-1:0];
	assign posy_c = (posy_raw_s3 > 28'(CellsY)) ? PosYW'(CellsY) : posy_raw_s3[PosYW-1:0];
	assign ix_c   = posx_c[PosXW-1:FRAC_BITS];
	assign jy_c   = posy_c[PosYW-1:FRAC_BITS];
	assign i_c    = (32'(ix_c) > 32'(GRID_X - 2)) ? RowW'(GRID_X - 2) : ix_c;
	assign j_c    = (32'(jy_c) > 32'(GRID_Y - 2)) ? ColW'(GRID_Y - 2) : jy_c;
	assign col_c  = ColW'(32'(eidx_s3) - 32'(row_s3) * 32'(GRID_Y));

	always_ff @(posedge clk) begin
		if (adv) begin
			work_ctl.kind <= kind_s3;
			work_ctl.flag <= flag_s3;
			work_tsel     <= tsel_s3;
			work_data     <= eval_s3;
			work_ft       <= FRAC_W'(posx_c - {i_c, 16'h0000});
			work_fs       <= FRAC_W'(posy_c - {j_c, 16'h0000});
			if (kind_s3 == KIND_STORE) begin
				work_row <= row_s3;
				work_col <= col_c;
			end else begin
				work_row <= i_c;
				work_col <= j_c;
			end
		end
	end

	assign work_valid = valid_s4;

endmodule

FILE: rtl/bgi_queue.sv
module bgi_queue #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             full,
	input  logic [Width-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [Width-1:0] pop_data
);
	localparam int PtrW = $clog2(Depth);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PtrW:0]    count_q;
	logic             push, pop;

	assign full      = count_q == (PtrW + 1)'(Depth);
	assign pop_valid = count_q != '0;
	assign push      = push_valid && !full;
	assign pop       = pop_ready && pop_valid;
	assign pop_data  = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PtrW + 1)'(push) - (PtrW + 1)'(pop);
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PtrW + 1)'(Depth))
		else $error("queue count beyond depth");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		PtrW'(wr_ptr_q - rd_ptr_q) == count_q[PtrW-1:0])
		else $error("queue pointers disagree with count");

endmodule

FILE: rtl/bgi_back.sv
module bgi_back #(
	parameter int GRID_X = 80,
	parameter int GRID_Y = 80,
	parameter int TABLE_COUNT = 4,
	localparam int RowW = $clog2(GRID_X),
	localparam int ColW = $clog2(GRID_Y)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           work_valid,
	output logic                           work_pop,
	input  bgi_pkg::ctl_t                  work_ctl,
	input  logic [bgi_pkg::TSEL_W-1:0]     work_tsel,
	input  logic [RowW-1:0]                work_row,
	input  logic [ColW-1:0]                work_col,
	input  logic [bgi_pkg::FRAC_W-1:0]     work_ft,
	input  logic [bgi_pkg::FRAC_W-1:0]     work_fs,
	input  logic [bgi_pkg::WORD_W-1:0]     work_data,
	bgi_result_if.source                   result
);
	import bgi_pkg::*;

	// Four banks split by row and column parity; each holds a quarter grid.
	localparam int HalfX     = (GRID_X + 1) / 2;
	localparam int HalfY     = (GRID_Y + 1) / 2;
	localparam int BankDepth = TABLE_COUNT * HalfX * HalfY;
	localparam int BankAw    = $clog2(BankDepth);

	logic adv;
	logic valid_s5, valid_s6, valid_s7, valid_s8, valid_s9;
	logic out_valid_q;

	ctl_t              ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;
	logic [TSEL_W-1:0] tsel_s5;
	logic [RowW-1:0]   row_s5, row_s6;
	logic [ColW-1:0]   col_s5, col_s6;
	logic [FRAC_W-1:0] ft_s5, ft_s6, ft_s7, ft_s8;
	logic [FRAC_W-1:0] fs_s5, fs_s6;
	logic [WORD_W-1:0] data_s5;
	logic [WORD_W-1:0] bank_rd_s6 [4];

	logic signed [WORD_W-1:0] a00_c, a01_c, a10_c, a11_c;
	logic signed [50:0]       prod0_c, prod1_c, prod0_s7, prod1_s7;
	logic signed [WORD_W-1:0] a00_s7, a10_s7;
	logic signed [50:0]       rnd0_c, rnd1_c;
	logic signed [WORD_W-1:0] v0_c, v1_c, v0_s8, v1_s8;
	logic signed [50:0]       prod_c, prod_s9, rnd_c;
	logic signed [WORD_W-1:0] v0_s9, v_c;
	logic signed [WORD_W-1:0] value_q;
	logic                     oor_q;

	// The whole back end moves together unless the result is held.
	assign adv      = !out_valid_q || result.ready;
	assign work_pop = adv && work_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			valid_s8    <= 1'b0;
			valid_s9    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s5    <= work_valid;
			valid_s6    <= valid_s5;
			valid_s7    <= valid_s6;
			valid_s8    <= valid_s7;
			valid_s9    <= valid_s8;
			out_valid_q <= valid_s9;
		end
	end

	// Word taken from the queue.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s5  <= work_ctl;
			tsel_s5 <= work_tsel;
			row_s5  <= work_row;
			col_s5  <= work_col;
			ft_s5   <= work_ft;
			fs_s5   <= work_fs;
			data_s5 <= work_data;
		end
	end

	// Table banks: a store hits one bank, a lookup reads one corner from each.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic RowPar = (b >= 2);
		localparam logic ColPar = (b % 2 == 1);

		logic [WORD_W-1:0] mem [BankDepth];
		logic [WORD_W-1:0] rd_s6;
		logic [RowW:0]     r;
		logic [ColW:0]     c;
		logic [BankAw-1:0] addr;
		logic              we, re;

		assign r    = (RowW + 1)'(row_s5) + (RowW + 1)'(row_s5[0] != RowPar);
		assign c    = (ColW + 1)'(col_s5) + (ColW + 1)'(col_s5[0] != ColPar);
		assign addr = BankAw'(32'(tsel_s5) * 32'(HalfX * HalfY) +
			32'(r[RowW:1]) * 32'(HalfY) + 32'(c[ColW:1]));
		assign we   = adv && valid_s5 && ctl_s5.kind == KIND_STORE &&
			row_s5[0] == RowPar && col_s5[0] == ColPar;
		assign re   = adv && valid_s5 && ctl_s5.kind == KIND_LOOKUP;

		always_ff @(posedge clk) begin
			if (we) mem[addr] <= data_s5;
			if (re) rd_s6 <= mem[addr];
		end

		assign bank_rd_s6[b] = rd_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s6 <= ctl_s5;
			row_s6 <= row_s5;
			col_s6 <= col_s5;
			ft_s6  <= ft_s5;
			fs_s6  <= fs_s5;
		end
	end

	// Route banks to corners and form the pressure-direction products.
	assign a00_c = signed'(bank_rd_s6[{row_s6[0], col_s6[0]}]);
	assign a01_c = signed'(bank_rd_s6[{row_s6[0], !col_s6[0]}]);
	assign a10_c = signed'(bank_rd_s6[{!row_s6[0], col_s6[0]}]);
	assign a11_c = signed'(bank_rd_s6[{!row_s6[0], !col_s6[0]}]);
	assign prod0_c = 51'(33'(a01_c) - 33'(a00_c)) * 51'(signed'({1'b0, fs_s6}));
	assign prod1_c = 51'(33'(a11_c) - 33'(a10_c)) * 51'(signed'({1'b0, fs_s6}));

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s7   <= ctl_s6;
			ft_s7    <= ft_s6;
			prod0_s7 <= prod0_c;
			prod1_s7 <= prod1_c;
			a00_s7   <= a00_c;
			a10_s7   <= a10_c;
		end
	end

	// Round half up and finish the two row blends.
	assign rnd0_c = prod0_s7 + 51'sd32768;
	assign rnd1_c = prod1_s7 + 51'sd32768;
	assign v0_c   = WORD_W'(33'(a00_s7) + 33'(rnd0_c >>> FRAC_BITS));
	assign v1_c   = WORD_W'(33'(a10_s7) + 33'(rnd1_c >>> FRAC_BITS));

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s8 <= ctl_s7;
			ft_s8  <= ft_s7;
			v0_s8  <= v0_c;
			v1_s8  <= v1_c;
		end
	end

	// Temperature-direction product.
	assign prod_c = 51'(33'(v1_s8) - 33'(v0_s8)) * 51'(signed'({1'b0, ft_s8}));

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s9  <= ctl_s8;
			prod_s9 <= prod_c;
			v0_s9   <= v0_s8;
		end
	end

	// Final blend into the output register.
	assign rnd_c = prod_s9 + 51'sd32768;
	assign v_c   = WORD_W'(33'(v0_s9) + 33'(rnd_c >>> FRAC_BITS));

	always_ff @(posedge clk) begin
		if (adv) begin
			value_q <= (ctl_s9.kind == KIND_LOOKUP) ? v_c : '0;
			oor_q   <= ctl_s9.flag;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.value        = value_q;
	assign result.out_of_range = oor_q;

endmodule

FILE: rtl/bilinear_grid_interpolator_top.sv
// Bilinear lookup over TABLE_COUNT property tables on a GRID_X by GRID_Y
// temperature-pressure grid. Each item on the item channel is either a table
// store (operation 1) or a lookup (operation 0), and every item returns exactly
// one word on the result channel, in order. One item is accepted per clock in
// steady state while the result channel keeps taking words. The rate is set by
// the table memory, split into four banks by row and column parity so that
// the four corners of a cell are read together through four single read ports.
// Tables power up undefined and need no clearing; every entry a lookup touches
// must have been stored first. The user writes configuration registers only
// while no item is in flight; the block itself does not enforce this.
module bilinear_grid_interpolator_top #(
	parameter int GRID_X      = bgi_pkg::GRID_X_DEFAULT,
	parameter int GRID_Y      = bgi_pkg::GRID_Y_DEFAULT,
	parameter int TABLE_COUNT = bgi_pkg::TABLE_COUNT_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	bgi_item_if.sink                      item,
	bgi_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bgi_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import bgi_pkg::*;

	localparam int RowW   = $clog2(GRID_X);
	localparam int ColW   = $clog2(GRID_Y);
	localparam int QWidth = $bits(ctl_t) + TSEL_W + RowW + ColW + 2 * FRAC_W + WORD_W;

	cfg_t              cfg_q;
	logic              reg_wr;
	logic [2:0]        reg_idx;

	logic              f_valid, q_full, q_valid, q_pop;
	ctl_t              f_ctl, b_ctl;
	logic [TSEL_W-1:0] f_tsel, b_tsel;
	logic [RowW-1:0]   f_row, b_row;
	logic [ColW-1:0]   f_col, b_col;
	logic [FRAC_W-1:0] f_ft, f_fs, b_ft, b_fs;
	logic [WORD_W-1:0] f_data, b_data;
	logic [QWidth-1:0] q_in, q_out;

	// Register file on the configuration port.
	assign pready  = 1'b1;
	assign reg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_low       <= X_LOW_RESET;
			cfg_q.x_high      <= X_HIGH_RESET;
			cfg_q.y_low       <= Y_LOW_RESET;
			cfg_q.y_high      <= Y_HIGH_RESET;
			cfg_q.x_scale     <= X_SCALE_RESET;
			cfg_q.y_scale     <= Y_SCALE_RESET;
			cfg_q.line_slope  <= LINE_SLOPE_RESET;
			cfg_q.line_offset <= LINE_OFFSET_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_X_LOW:       cfg_q.x_low       <= pwdata[17:0];
				REG_X_HIGH:      cfg_q.x_high      <= pwdata[17:0];
				REG_Y_LOW:       cfg_q.y_low       <= pwdata[19:0];
				REG_Y_HIGH:      cfg_q.y_high      <= pwdata[19:0];
				REG_X_SCALE:     cfg_q.x_scale     <= pwdata[23:0];
				REG_Y_SCALE:     cfg_q.y_scale     <= pwdata[23:0];
				REG_LINE_SLOPE:  cfg_q.line_slope  <= pwdata[15:0];
				REG_LINE_OFFSET: cfg_q.line_offset <= pwdata[17:0];
				default: ;
			endcase
		end
	end

	// Read-back of the register file.
	always_comb begin
		unique case (reg_idx)
			REG_X_LOW:       prdata = 32'(cfg_q.x_low);
			REG_X_HIGH:      prdata = 32'(cfg_q.x_high);
			REG_Y_LOW:       prdata = 32'(cfg_q.y_low);
			REG_Y_HIGH:      prdata = 32'(cfg_q.y_high);
			REG_X_SCALE:     prdata = 32'(cfg_q.x_scale);
			REG_Y_SCALE:     prdata = 32'(cfg_q.y_scale);
			REG_LINE_SLOPE:  prdata = 32'(cfg_q.line_slope);
			REG_LINE_OFFSET: prdata = 32'(cfg_q.line_offset);
			default:         prdata = '0;
		endcase
	end

	bgi_front #(
		.GRID_X(GRID_X), .GRID_Y(GRID_Y), .TABLE_COUNT(TABLE_COUNT)
	) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .item(item),
		.work_valid(f_valid), .work_full(q_full), .work_ctl(f_ctl),
		.work_tsel(f_tsel), .work_row(f_row), .work_col(f_col),
		.work_ft(f_ft), .work_fs(f_fs), .work_data(f_data)
	);

	// Words travel through the queue packed into one vector.
	assign q_in = {f_ctl, f_tsel, f_row, f_col, f_ft, f_fs, f_data};
	assign {b_ctl, b_tsel, b_row, b_col, b_ft, b_fs, b_data} = q_out;

	bgi_queue #(
		.Width(QWidth), .Depth(QUEUE_DEPTH)
	) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .full(q_full), .push_data(q_in),
		.pop_valid(q_valid), .pop_ready(q_pop), .pop_data(q_out)
	);

	bgi_back #(
		.GRID_X(GRID_X), .GRID_Y(GRID_Y), .TABLE_COUNT(TABLE_COUNT)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.work_valid(q_valid), .work_pop(q_pop), .work_ctl(b_ctl),
		.work_tsel(b_tsel), .work_row(b_row), .work_col(b_col),
		.work_ft(b_ft), .work_fs(b_fs), .work_data(b_data),
		.result(result)
	);

endmodule

FILE: tb/sv/bgi_checker.sv
`timescale 1ns / 100ps

// Watches the item, result and register ports, predicts every result word
// and compares it with what the block returns.
module bgi_checker (
	input  logic         clk,
	input  logic         arst_n,
	bgi_item_if          item,
	bgi_result_if        result,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic         pready,
	input  logic [bgi_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]  pwdata,
	output int           fail_count,
	output int           pending
);
	import bgi_pkg::*;

	localparam int NX = GRID_X_DEFAULT;
	localparam int NY = GRID_Y_DEFAULT;
	localparam int NT = TABLE_COUNT_DEFAULT;

	typedef struct {
		logic signed [31:0] value;
		logic               flag;
	} lookup_word_t;

	cfg_t               cfg;
	logic signed [31:0] prop_mem [NT*NX*NY];
	lookup_word_t       expected_words [$];

	// Position on the grid with 16 fraction bits, held at the grid edges.
	function automatic longint grid_point(input longint v, input longint low,
			input longint scale, input longint cells);
		longint p;
		if (v <= low)
			return 0;
		p = ((v - low) * scale) >>> 16;
		if (p > (cells << 16))
			p = cells << 16;
		return p;
	endfunction

	// Linear blend with rounding half up.
	function automatic longint mix(input longint a, input longint b, input longint f);
		longint p;
		p = (b - a) * f + 32768;
		return a + (p >>> 16);
	endfunction

	function automatic longint entry_at(input int base, input int row, input int col);
		return longint'(prop_mem[base + row*NY + col]);
	endfunction

	// Expected result word for one accepted item; stores take effect here.
	function automatic lookup_word_t interpolate(input logic op, input logic [1:0] tsel,
			input logic [17:0] temp, input logic [19:0] pres, input logic [12:0] idx,
			input logic signed [31:0] val);
		lookup_word_t w;
		longint px, py, lhs, rhs, v0, v1;
		int     i, j, base;
		w.value = '0;
		w.flag  = 1'b0;
		if (op) begin
			if (tsel < NT && idx < NX*NY)
				prop_mem[tsel*NX*NY + idx] = val;
			return w;
		end
		if (tsel >= NT) begin
			w.flag = 1'b1;
			return w;
		end
		if (temp < cfg.x_low || temp > cfg.x_high || pres < cfg.y_low || pres > cfg.y_high)
			w.flag = 1'b1;
		lhs = longint'(temp) << 16;
		rhs = (longint'(cfg.line_offset) << 16) + longint'(cfg.line_slope) * longint'(pres);
		if (lhs >= rhs)
			w.flag = 1'b1;
		px = grid_point(longint'(temp), longint'(cfg.x_low), longint'(cfg.x_scale),
			longint'(NX - 1));
		py = grid_point(longint'(pres), longint'(cfg.y_low), longint'(cfg.y_scale),
			longint'(NY - 1));
		i = int'(px >>> 16);
		if (i > NX - 2)
			i = NX - 2;
		j = int'(py >>> 16);
		if (j > NY - 2)
			j = NY - 2;
		base = tsel * NX * NY;
		v0 = mix(entry_at(base, i, j), entry_at(base, i, j + 1), py - (longint'(j) << 16));
		v1 = mix(entry_at(base, i + 1, j), entry_at(base, i + 1, j + 1),
			py - (longint'(j) << 16));
		w.value = 32'(mix(v0, v1, px - (longint'(i) << 16)));
		return w;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		foreach (prop_mem[k])
			prop_mem[k] = '0;
	end

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		lookup_word_t got, want;
		if (!arst_n) begin
			cfg.x_low       <= X_LOW_RESET;
			cfg.x_high      <= X_HIGH_RESET;
			cfg.y_low       <= Y_LOW_RESET;
			cfg.y_high      <= Y_HIGH_RESET;
			cfg.x_scale     <= X_SCALE_RESET;
			cfg.y_scale     <= Y_SCALE_RESET;
			cfg.line_slope  <= LINE_SLOPE_RESET;
			cfg.line_offset <= LINE_OFFSET_RESET;
		end else begin
			// Register writes on the configuration port.
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_X_LOW:       cfg.x_low       <= pwdata[17:0];
					REG_X_HIGH:      cfg.x_high      <= pwdata[17:0];
					REG_Y_LOW:       cfg.y_low       <= pwdata[19:0];
					REG_Y_HIGH:      cfg.y_high      <= pwdata[19:0];
					REG_X_SCALE:     cfg.x_scale     <= pwdata[23:0];
					REG_Y_SCALE:     cfg.y_scale     <= pwdata[23:0];
					REG_LINE_SLOPE:  cfg.line_slope  <= pwdata[15:0];
					REG_LINE_OFFSET: cfg.line_offset <= pwdata[17:0];
					default: ;
				endcase
			end
			// Each accepted word yields one expected result word.
			if (item.valid && item.ready)
				expected_words.push_back(interpolate(item.operation, item.table_select,
					item.temperature, item.pressure, item.entry_index, item.entry_value));
			// Compare returned words against the oldest expectation.
			if (result.valid && result.ready) begin
				got.value = result.value;
				got.flag  = result.out_of_range;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("unexpected result word value %0d flag %0b",
						got.value, got.flag));
				end else begin
					want = expected_words.pop_front();
					if (got.value !== want.value)
						report_mismatch($sformatf("value %0d, expected %0d",
							got.value, want.value));
					if (got.flag !== want.flag)
						report_mismatch($sformatf("out_of_range %0b, expected %0b",
							got.flag, want.flag));
				end
			end
		end
	end
endmodule

FILE: tb/sv/tb_bilinear_grid_interpolator_top.sv
`timescale 1ns / 100ps

module tb_bilinear_grid_interpolator_top;
	import bgi_pkg::*;

	localparam int NX          = GRID_X_DEFAULT;
	localparam int NY          = GRID_Y_DEFAULT;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          fail_count;
	int          pending;
	int          cycle_count;
	int          burst_left;
	logic        hold_req;
	logic [31:0] reg_shadow [8];
	bit          stored [TABLE_COUNT_DEFAULT][NX*NY];

	bgi_item_if   item ();
	bgi_result_if result ();

	bilinear_grid_interpolator_top uut (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	bgi_checker chk (
		.clk(clk), .arst_n(arst_n), .item(item), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("bilinear_grid_interpolator_top test failed");
				$finish;
			end
		end
	end

	// Receiver: switches among random stall patterns, and holds off for a long
	// stretch when asked.
	initial begin
		int mode;
		result.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			repeat (64) begin
				@(negedge clk);
				if (hold_req) begin
					result.ready = 1'b0;
					repeat (300) @(negedge clk);
					hold_req = 1'b0;
				end
				case (mode)
					0: result.ready = 1'b1;
					1: result.ready = ($urandom_range(0, 1) == 0);
					2: result.ready = ($urandom_range(0, 3) == 0);
					default: result.ready = ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		reg_shadow[idx] = val;
	endtask

	// Sends one word; the sender runs in bursts with random gaps.
	task automatic send_word(input logic op, input logic [1:0] tsel, input logic [17:0] temp,
			input logic [19:0] pres, input logic [12:0] idx, input logic [31:0] val);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				item.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		item.valid        = 1'b1;
		item.operation    = op;
		item.table_select = tsel;
		item.temperature  = temp;
		item.pressure     = pres;
		item.entry_index  = idx;
		item.entry_value  = val;
		do @(posedge clk); while (!item.ready);
		if (op && idx < NX*NY)
			stored[tsel][idx] = 1'b1;
	endtask

	task automatic drain();
		@(negedge clk);
		item.valid = 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	function automatic logic [31:0] random_entry();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'(int'($urandom_range(0, 2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	function automatic int cell_index(input longint v, input longint low,
			input longint scale, input int cells);
		longint p;
		p = (v <= low) ? 0 : ((v - low) * scale) >>> 16;
		if (p > (longint'(cells) << 16))
			p = longint'(cells) << 16;
		p = p >>> 16;
		return (p > cells - 1) ? cells - 1 : int'(p);
	endfunction

	// Lookup, with any unstored corner of its cell stored first.
	task automatic lookup(input logic [1:0] tsel, input logic [17:0] temp,
			input logic [19:0] pres);
		int i, j, k;
		i = cell_index(longint'(temp), longint'(reg_shadow[REG_X_LOW]),
			longint'(reg_shadow[REG_X_SCALE]), NX - 1);
		j = cell_index(longint'(pres), longint'(reg_shadow[REG_Y_LOW]),
			longint'(reg_shadow[REG_Y_SCALE]), NY - 1);
		for (int di = 0; di < 2; di++)
			for (int dj = 0; dj < 2; dj++) begin
				k = (i + di) * NY + j + dj;
				if (!stored[tsel][k])
					send_word(1'b1, tsel, 18'($urandom), 20'($urandom), 13'(k),
						random_entry());
			end
		send_word(1'b0, tsel, temp, pres, 13'($urandom), $urandom);
	endtask

	task automatic set_regs(input logic [31:0] xl, input logic [31:0] xh,
			input logic [31:0] yl, input logic [31:0] yh, input logic [31:0] xs,
			input logic [31:0] ys, input logic [31:0] sl, input logic [31:0] off);
		reg_write(REG_X_LOW, xl);
		reg_write(REG_X_HIGH, xh);
		reg_write(REG_Y_LOW, yl);
		reg_write(REG_Y_HIGH, yh);
		reg_write(REG_X_SCALE, xs);
		reg_write(REG_Y_SCALE, ys);
		reg_write(REG_LINE_SLOPE, sl);
		reg_write(REG_LINE_OFFSET, off);
	endtask

	// Random mix: mostly in-range lookups, some full-range noise and stores.
	task automatic random_phase(input int count);
		logic [17:0] t;
		logic [19:0] p;
		logic [31:0] xl, xh, yl, yh;
		xl = reg_shadow[REG_X_LOW];
		xh = reg_shadow[REG_X_HIGH];
		yl = reg_shadow[REG_Y_LOW];
		yh = reg_shadow[REG_Y_HIGH];
		repeat (count) begin
			case ($urandom_range(0, 9))
				0, 1: send_word(1'b1, 2'($urandom), 18'($urandom), 20'($urandom),
					13'($urandom), random_entry());
				2: lookup(2'($urandom), 18'($urandom), 20'($urandom));
				default: begin
					t = (xl <= xh) ? 18'($urandom_range(xl, xh)) : 18'($urandom);
					p = (yl <= yh) ? 20'($urandom_range(yl, yh)) : 20'($urandom);
					lookup(2'($urandom), t, p);
				end
			endcase
		end
	endtask

	initial begin
		logic [31:0] xl, yl;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		hold_req = 1'b0;
		burst_left = 0;
		item.valid = 1'b0; item.operation = 1'b0; item.table_select = '0;
		item.temperature = '0; item.pressure = '0; item.entry_index = '0;
		item.entry_value = '0;
		reg_shadow[REG_X_LOW]       = X_LOW_RESET;
		reg_shadow[REG_X_HIGH]      = X_HIGH_RESET;
		reg_shadow[REG_Y_LOW]       = Y_LOW_RESET;
		reg_shadow[REG_Y_HIGH]      = Y_HIGH_RESET;
		reg_shadow[REG_X_SCALE]     = X_SCALE_RESET;
		reg_shadow[REG_Y_SCALE]     = Y_SCALE_RESET;
		reg_shadow[REG_LINE_SLOPE]  = LINE_SLOPE_RESET;
		reg_shadow[REG_LINE_OFFSET] = LINE_OFFSET_RESET;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: extreme entries, grid corners, limit line, ignored stores.
		send_word(1'b1, 2'd0, '0, '0, 13'd0, 32'h7fff_ffff);
		send_word(1'b1, 2'd0, '1, '1, 13'd1, 32'h8000_0000);
		send_word(1'b1, 2'd3, '0, '0, 13'd6399, 32'h8000_0000);
		send_word(1'b1, 2'd2, '1, '1, 13'd8191, 32'h1234_5678);
		send_word(1'b1, 2'd1, '0, '0, 13'd6400, 32'hffff_ffff);
		lookup(2'd0, X_LOW_RESET, Y_LOW_RESET);
		lookup(2'd0, '0, '0);
		lookup(2'd3, '1, '1);
		lookup(2'd1, X_HIGH_RESET, Y_HIGH_RESET);
		lookup(2'd2, 18'd116480, Y_LOW_RESET);
		lookup(2'd2, 18'd116479, Y_LOW_RESET);
		lookup(2'd0, 18'd90000, 20'd300000);
		random_phase(16);

		// Long receiver hold while the sender keeps offering words.
		@(negedge clk);
		item.valid = 1'b0;
		hold_req = 1'b1;
		burst_left = 40;
		random_phase(10);
		drain();
		random_phase(6);
		drain();

		// Widest ranges, steepest scales, limit line at the highest temperature.
		set_regs(32'd0, 32'h3ffff, 32'd0, 32'hfffff, 32'hffffff, 32'hffffff,
			32'd0, 32'h3ffff);
		random_phase(20);
		drain();

		// Zero scales and the steepest limit line.
		set_regs(32'h3ffff, 32'd0, 32'hfffff, 32'd0, 32'd0, 32'd0, 32'hffff, 32'd0);
		random_phase(12);
		drain();

		// Random grids sized so the range covers the whole table.
		repeat (3) begin
			xl = $urandom_range(0, 100000);
			yl = $urandom_range(0, 400000);
			set_regs(xl, xl + 80000, yl, yl + 500000,
				32'((longint'(NX - 1) << 32) / 80000),
				32'((longint'(NY - 1) << 32) / 500000),
				$urandom_range(0, 65535), $urandom_range(0, 262143));
			random_phase(15);
			drain();
		end

		if (fail_count == 0)
			$display("bilinear_grid_interpolator_top test passed");
		else
			$display("bilinear_grid_interpolator_top test failed");
		$finish;
	end
endmodule

FILE: files.f
rtl/bgi_pkg.sv
rtl/bgi_ifs.sv
rtl/bgi_front.sv
rtl/bgi_queue.sv
rtl/bgi_back.sv
rtl/bilinear_grid_interpolator_top.sv
tb/sv/bgi_checker.sv
tb/sv/tb_bilinear_grid_interpolator_top.sv
